FILE: src/chd_pkg.sv
// Shared types and constants for the CI Hamiltonian diagonal-energy block.
// Used by the top level and by its checker; has no dependencies.
`timescale 1ns / 1ps

package chd_pkg;

    // Fixed field widths.
    localparam int OCC_W    = 16;  // occupation mask bits
    localparam int IDX_IN_W = 4;   // row and column index fields
    localparam int VAL_W    = 32;  // integral entries
    localparam int CNT_W    = 5;   // orbital_count register
    localparam int ENERGY_W = 48;  // energy result
    localparam int TERM_W   = 36;  // doubled contribution of one orbital pair
    localparam int ACC_W    = 50;  // doubled running sum
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [CNT_W-1:0] ORBITAL_COUNT_RESET = 5'd16;

    // Register indexes on the configuration port (paddr[2]).
    localparam logic REG_ORBITAL_COUNT = 1'b0;

    // Operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [2:0] {
        TBL_CORE_A = 3'd0,
        TBL_CORE_B = 3'd1,
        TBL_J_A    = 3'd2,
        TBL_K_A    = 3'd3,
        TBL_J_B    = 3'd4,
        TBL_K_B    = 3'd5,
        TBL_J_MIX  = 3'd6
    } t_table_sel;

    // Lanes of the pair memory word and of the core memory word.
    localparam int PAIR_LANES = 5;
    localparam int PLANE_W    = 3;
    localparam logic [PLANE_W-1:0] LANE_JA = 3'd0;
    localparam logic [PLANE_W-1:0] LANE_KA = 3'd1;
    localparam logic [PLANE_W-1:0] LANE_JB = 3'd2;
    localparam logic [PLANE_W-1:0] LANE_KB = 3'd3;
    localparam logic [PLANE_W-1:0] LANE_JM = 3'd4;

    localparam int CORE_LANES = 2;
    localparam logic LANE_CA = 1'b0;
    localparam logic LANE_CB = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

endpackage

FILE: src/ci_hamiltonian_diagonal.sv
// Top level of the CI Hamiltonian diagonal-energy block: integral memories,
// pair sequencer, accumulator and configuration port. Depends on chd_pkg.
`timescale 1ns / 1ps

// A load transaction writes one integral entry and returns nothing; the block
// takes the next transaction in the following cycle. An evaluate transaction
// walks all n by n orbital pairs, n being the smaller of orbital_count and
// the table size, one pair per cycle through the single read port of the pair
// memory, so it holds the input stalled from its accept edge until its result
// is loaded into the output register. The result sits in that register, so a
// new transaction is accepted while it waits; an evaluation that finishes
// while an earlier result is still waiting keeps the input stalled until that
// result is taken.
// The integral tables are not cleared by reset; every entry an evaluation
// reads must have been loaded first.
module ci_hamiltonian_diagonal #(
    parameter int MAX_ORBITALS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Item channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic [2:0]                        i_table_select,
    input  logic [chd_pkg::IDX_IN_W-1:0]      i_row_index,
    input  logic [chd_pkg::IDX_IN_W-1:0]      i_col_index,
    input  logic signed [chd_pkg::VAL_W-1:0]  i_entry_value,
    input  logic [chd_pkg::OCC_W-1:0]         i_alpha_occupation,
    input  logic [chd_pkg::OCC_W-1:0]         i_beta_occupation,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [chd_pkg::ENERGY_W-1:0] o_diagonal_energy,
    output logic                              o_saturated,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [chd_pkg::PADDR_W-1:0]       paddr,
    input  logic [chd_pkg::PDATA_W-1:0]       pwdata,
    output logic [chd_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import chd_pkg::*;

    // Orbitals actually addressable: limited by the 16-bit occupation masks.
    localparam int KE         = (MAX_ORBITALS < OCC_W) ? MAX_ORBITALS : OCC_W;
    localparam int IDX_W      = $clog2(KE);
    localparam int PAIR_DEPTH = 1 << (2 * IDX_W);

    // ---------------- configuration ----------------
    logic [CNT_W-1:0] r_orbital_count;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ORBITAL_COUNT)
                     ? PDATA_W'(r_orbital_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orbital_count <= ORBITAL_COUNT_RESET;
        end else if (cfg_write && paddr[2] == REG_ORBITAL_COUNT) begin
            r_orbital_count <= pwdata[CNT_W-1:0];
        end
    end

    // ---------------- control ----------------
    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_p, r_q, r_last;
    logic [KE-1:0]        r_alpha, r_beta;
    logic                 in_accept;
    logic [CNT_W-1:0]     n_eff;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign n_eff      = (r_orbital_count > CNT_W'(KE)) ? CNT_W'(KE) : r_orbital_count;

    // ---------------- memories ----------------
    // Loads are written at their accept edge, only while idle; the read registers
    // load every cycle, but their data is used only while an evaluation runs.
    logic [VAL_W-1:0] r_pair_mem [PAIR_DEPTH][PAIR_LANES];
    logic [VAL_W-1:0] r_core_mem [KE][CORE_LANES];
    logic [VAL_W-1:0] r_pair_rd  [PAIR_LANES];
    logic [VAL_W-1:0] r_core_rd  [CORE_LANES];

    t_table_sel          wsel;
    logic                load_ok_row, load_ok_col;
    logic                pair_we, core_we;
    logic [PLANE_W-1:0]  pair_lane;
    logic                core_lane;
    logic [2*IDX_W-1:0]  pair_waddr, pair_raddr;

    assign wsel        = t_table_sel'(i_table_select);
    assign load_ok_row = ({1'b0, i_row_index} < (IDX_IN_W + 1)'(KE));
    assign load_ok_col = ({1'b0, i_col_index} < (IDX_IN_W + 1)'(KE));
    assign pair_waddr  = {i_row_index[IDX_W-1:0], i_col_index[IDX_W-1:0]};
    assign pair_raddr  = {r_p, r_q};

    always_comb begin
        pair_we   = 1'b0;
        core_we   = 1'b0;
        pair_lane = LANE_JA;
        core_lane = LANE_CA;
        if (in_accept && i_operation == OP_LOAD && load_ok_row) begin
            unique case (wsel)
                TBL_CORE_A: begin core_we = 1'b1; core_lane = LANE_CA; end
                TBL_CORE_B: begin core_we = 1'b1; core_lane = LANE_CB; end
                TBL_J_A:    begin pair_we = load_ok_col; pair_lane = LANE_JA; end
                TBL_K_A:    begin pair_we = load_ok_col; pair_lane = LANE_KA; end
                TBL_J_B:    begin pair_we = load_ok_col; pair_lane = LANE_JB; end
                TBL_K_B:    begin pair_we = load_ok_col; pair_lane = LANE_KB; end
                TBL_J_MIX:  begin pair_we = load_ok_col; pair_lane = LANE_JM; end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pair_we) begin
            r_pair_mem[pair_waddr][pair_lane] <= i_entry_value;
        end
        if (core_we) begin
            r_core_mem[i_row_index[IDX_W-1:0]][core_lane] <= i_entry_value;
        end
        r_pair_rd <= r_pair_mem[pair_raddr];
        r_core_rd <= r_core_mem[r_p];
    end

    // ---------------- pair pipeline ----------------
    // Stage 1 holds the flags of the pair whose data the memories return now.
    // The mixed term is counted once with weight two: the beta-side sum over
    // Jm[q][p] equals the alpha-side sum over Jm[p][q].
    logic r_s1_valid, r_s1_same_a, r_s1_same_b, r_s1_mix, r_s1_core_a, r_s1_core_b;
    logic r_s2_valid;
    logic signed [TERM_W-1:0] term, r_term;
    logic signed [ACC_W-1:0]  r_acc;
    logic ap, bp, aq, bq, off_diag;

    assign ap       = r_alpha[r_p];
    assign bp       = r_beta[r_p];
    assign aq       = r_alpha[r_q];
    assign bq       = r_beta[r_q];
    assign off_diag = (r_p != r_q);

    always_ff @(posedge i_clk) begin
        r_s1_same_a <= ap && aq && off_diag;
        r_s1_same_b <= bp && bq && off_diag;
        r_s1_mix    <= ap && bq;
        r_s1_core_a <= ap && (r_q == '0);
        r_s1_core_b <= bp && (r_q == '0);
        r_term      <= term;
    end

    always_comb begin
        term = '0;
        if (r_s1_same_a) begin
            term = term + TERM_W'(signed'(r_pair_rd[LANE_JA]))
                        - TERM_W'(signed'(r_pair_rd[LANE_KA]));
        end
        if (r_s1_same_b) begin
            term = term + TERM_W'(signed'(r_pair_rd[LANE_JB]))
                        - TERM_W'(signed'(r_pair_rd[LANE_KB]));
        end
        if (r_s1_mix) begin
            term = term + (TERM_W'(signed'(r_pair_rd[LANE_JM])) <<< 1);
        end
        if (r_s1_core_a) begin
            term = term + (TERM_W'(signed'(r_core_rd[LANE_CA])) <<< 1);
        end
        if (r_s1_core_b) begin
            term = term + (TERM_W'(signed'(r_core_rd[LANE_CB])) <<< 1);
        end
    end

    // ---------------- result ----------------
    logic signed [ACC_W-1:0]    half;
    logic                       sat_hi, sat_lo;
    logic signed [ENERGY_W-1:0] energy;
    logic                       out_load;

    assign half   = r_acc >>> 1;  // floor of half the doubled sum
    assign sat_hi = !half[ACC_W-1] && (|half[ACC_W-2:ENERGY_W-1]);
    assign sat_lo = half[ACC_W-1] && !(&half[ACC_W-2:ENERGY_W-1]);

    always_comb begin
        priority if (sat_hi) begin
            energy = {1'b0, {(ENERGY_W-1){1'b1}}};
        end else if (sat_lo) begin
            energy = {1'b1, {(ENERGY_W-1){1'b0}}};
        end else begin
            energy = half[ENERGY_W-1:0];
        end
    end

    assign out_load = (r_state == ST_FINISH) && (!o_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_diagonal_energy <= energy;
            o_saturated       <= sat_hi || sat_lo;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && i_operation == OP_EVAL) begin
                    n_state = (n_eff == '0) ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_q == r_last && r_p == r_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_s1_valid && !r_s2_valid) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= (r_state == ST_RUN);
            r_s2_valid <= r_s1_valid;
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_p     <= '0;
            r_q     <= '0;
            r_last  <= IDX_W'(n_eff - CNT_W'(1));
            r_acc   <= '0;
            r_alpha <= i_alpha_occupation[KE-1:0];
            r_beta  <= i_beta_occupation[KE-1:0];
        end else begin
            if (r_state == ST_RUN) begin
                if (r_q == r_last) begin
                    r_q <= '0;
                    r_p <= r_p + IDX_W'(1);
                end else begin
                    r_q <= r_q + IDX_W'(1);
                end
            end
            if (r_s2_valid) begin
                r_acc <= r_acc + ACC_W'(r_term);
            end
        end
    end

endmodule

FILE: src/chd_checker.sv
// Port-level checker for ci_hamiltonian_diagonal, attached by a bind at the
// end of this file. Depends on chd_pkg.
`timescale 1ns / 1ps

module chd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              i_operation,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [chd_pkg::ENERGY_W-1:0] o_diagonal_energy,
    input logic                              o_saturated
);
    import chd_pkg::*;

    localparam logic signed [ENERGY_W-1:0] E_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam logic signed [ENERGY_W-1:0] E_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_diagonal_energy)
            && $stable(o_saturated))
        else $error("result changed while stalled");

    // An evaluation occupies the block after it is accepted.
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_operation == OP_EVAL |=> o_in_stall)
        else $error("input not stalled after an evaluation transaction");

    // A load leaves the input unstalled in the following cycle.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_operation == OP_LOAD |=> !o_in_stall)
        else $error("input stalled after a load transaction");

    // A clamped energy sits at one end of the range.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            o_diagonal_energy == E_MAX || o_diagonal_energy == E_MIN)
        else $error("saturated result not at a range limit");

    // A new result only appears at the end of an evaluation.
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a running evaluation");

endmodule

bind ci_hamiltonian_diagonal chd_checker u_chd_checker (.*);
